[rtl/mau_pkg.sv]
// Shared constants, codes and controller/datapath interface types for the modular arithmetic unit.
package mau_pkg;

  localparam int MOD_W  = 31;
  localparam int OPA_W  = 64;
  localparam int OPB_W  = 31;
  localparam int EXP_W  = 63;
  localparam int ACT_W  = 3;
  localparam int DVD_W  = 64;
  localparam int PROD_W = 2 * MOD_W;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [MOD_W-1:0] RESET_MODULUS = 31'd1000000007;

  // Action codes; code 7 is unused and returns zero.
  localparam logic [ACT_W-1:0] ACT_REDUCE   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_ADD      = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SUBTRACT = 3'd2;
  localparam logic [ACT_W-1:0] ACT_NEGATE   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_MULTIPLY = 3'd4;
  localparam logic [ACT_W-1:0] ACT_DIVIDE   = 3'd5;
  localparam logic [ACT_W-1:0] ACT_POWER    = 3'd6;

  // Register address of the modulus (word select bit of paddr).
  localparam logic REG_MODULUS = 1'b0;

  typedef enum logic [1:0] {DIV_SRC_A, DIV_SRC_B, DIV_SRC_PROD} div_src_t;
  typedef enum logic [1:0] {MUL_AB, MUL_ACC_BASE, MUL_SQUARE, MUL_FINAL} mul_sel_t;
  typedef enum logic [2:0] {WR_NONE, WR_A, WR_B, WR_ACC, WR_BASE, WR_RES} wr_dst_t;
  typedef enum logic [1:0] {RES_HOLD, RES_SIMPLE, RES_ZERO, RES_ACC} res_op_t;
  typedef enum logic [1:0] {PW_NONE, PW_DIV, PW_POW} pw_init_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_src_t div_src;
    logic     mul_start;
    mul_sel_t mul_sel;
    wr_dst_t  wr_dst;
    res_op_t  res_op;
    pw_init_t pw_init;
    logic     e_shift;
    logic     out_load;
  } mau_cmd_t;

  typedef struct packed {
    logic             div_busy;
    logic             e_zero;
    logic             e_lsb;
    logic             m_small;
    logic [ACT_W-1:0] act;
  } mau_status_t;

endpackage

[rtl/mau_datapath.sv]
// Datapath: operand registers, multiplier, bit-serial remainder unit, exponent register.
module mau_datapath import mau_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  mau_cmd_t                cmd,
  input  logic [ACT_W-1:0]        action,
  input  logic signed [OPA_W-1:0] operand_a,
  input  logic [OPB_W-1:0]        operand_b,
  input  logic [EXP_W-1:0]        exponent,
  input  logic [MOD_W-1:0]        modulus,
  output mau_status_t             status,
  output logic [MOD_W-1:0]        result
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [ACT_W-1:0]  act_r;
  logic              neg_r;
  logic [OPA_W-1:0]  amag_r;
  logic [OPB_W-1:0]  bin_r;
  logic [EXP_W-1:0]  exp_r;
  logic [MOD_W-1:0]  a_r, b_r, acc_r, base_r, res_r, rem_r;
  logic [EXP_W-1:0]  e_r;
  logic [PROD_W-1:0] prod_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;

  logic [OPA_W-1:0]  a_raw, amag_in;
  logic [MOD_W:0]    t, sum, sum_red, diff;
  logic [MOD_W-1:0]  rem_step, fix_a, neg_v, simple_v, mx, my;
  logic [DVD_W-1:0]  dvd_src;

  // operand a magnitude and sign
  always_comb begin
    a_raw   = $unsigned(operand_a);
    amag_in = a_raw[OPA_W-1] ? (OPA_W'(0) - a_raw) : a_raw;
  end

  // one restoring step: shift in next dividend bit, subtract modulus if it fits
  always_comb begin
    t        = {rem_r, dvd_r[DVD_W-1]};
    rem_step = (t >= {1'b0, modulus}) ? MOD_W'(t - {1'b0, modulus}) : t[MOD_W-1:0];
    if (!neg_r) begin
      fix_a = rem_r;
    end else if (rem_r != '0) begin
      fix_a = modulus - rem_r;
    end else begin
      fix_a = '0;
    end
  end

  // single-correction add, subtract, negate
  always_comb begin
    sum     = {1'b0, a_r} + {1'b0, b_r};
    sum_red = (sum >= {1'b0, modulus}) ? (sum - {1'b0, modulus}) : sum;
    diff    = {1'b0, a_r} - {1'b0, b_r};
    if (a_r < b_r) begin
      diff = diff + {1'b0, modulus};
    end
    neg_v = (a_r != '0) ? (modulus - a_r) : '0;
    unique case (act_r)
      ACT_REDUCE:   simple_v = a_r;
      ACT_ADD:      simple_v = sum_red[MOD_W-1:0];
      ACT_SUBTRACT: simple_v = diff[MOD_W-1:0];
      ACT_NEGATE:   simple_v = neg_v;
      default:      simple_v = '0;
    endcase
  end

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_AB:       begin mx = a_r;    my = b_r;    end
      MUL_ACC_BASE: begin mx = acc_r;  my = base_r; end
      MUL_SQUARE:   begin mx = base_r; my = base_r; end
      MUL_FINAL:    begin mx = a_r;    my = acc_r;  end
    endcase
    unique case (cmd.div_src)
      DIV_SRC_A:    dvd_src = amag_r;
      DIV_SRC_B:    dvd_src = DVD_W'(bin_r);
      DIV_SRC_PROD: dvd_src = DVD_W'(prod_r);
      default:      dvd_src = '0;
    endcase
  end

  // remainder unit control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (cmd.div_start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(DVD_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= action;
      neg_r  <= a_raw[OPA_W-1];
      amag_r <= amag_in;
      bin_r  <= operand_b;
      exp_r  <= exponent;
    end
    if (cmd.div_start) begin
      dvd_r <= dvd_src;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= rem_step;
    end
    if (cmd.mul_start) begin
      prod_r <= PROD_W'(mx) * PROD_W'(my);
    end
    unique case (cmd.pw_init)
      PW_DIV: begin
        base_r <= b_r;
        e_r    <= EXP_W'(modulus - MOD_W'(2));
        acc_r  <= MOD_W'(1);
      end
      PW_POW: begin
        base_r <= a_r;
        e_r    <= exp_r;
        acc_r  <= MOD_W'(1);
      end
      default: begin
        if (cmd.e_shift) begin
          e_r <= e_r >> 1;
        end
        if (cmd.wr_dst == WR_ACC) begin
          acc_r <= rem_r;
        end
        if (cmd.wr_dst == WR_BASE) begin
          base_r <= rem_r;
        end
      end
    endcase
    if (cmd.wr_dst == WR_A) begin
      a_r <= fix_a;
    end
    if (cmd.wr_dst == WR_B) begin
      b_r <= rem_r;
    end
    if (cmd.wr_dst == WR_RES) begin
      res_r <= rem_r;
    end else begin
      unique case (cmd.res_op)
        RES_SIMPLE: res_r <= simple_v;
        RES_ZERO:   res_r <= '0;
        RES_ACC:    res_r <= acc_r;
        default:    res_r <= res_r;
      endcase
    end
    if (cmd.out_load) begin
      result <= res_r;
    end
  end

  always_comb begin
    status.div_busy = busy_r;
    status.e_zero   = (e_r == '0);
    status.e_lsb    = e_r[0];
    status.m_small  = (modulus < MOD_W'(2));
    status.act      = act_r;
  end

endmodule

[rtl/mau_ctrl.sv]
// Controller: sequences reductions, multiplies and the square-and-multiply loop.
module mau_ctrl import mau_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  mau_status_t status,
  output mau_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_RA, S_RA_W, S_RB, S_RB_W, S_DISP,
    S_MUL, S_MDIV, S_MWAIT, S_PCHK, S_OUT
  } state_t;

  state_t   state, state_next;
  mul_sel_t kind, kind_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    kind_next   = kind;
    cmd         = '0;
    cmd.mul_sel = kind;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (status.m_small) begin
            cmd.res_op = RES_ZERO;
            state_next = S_OUT;
          end else begin
            state_next = S_RA;
          end
        end
      end
      S_RA: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = DIV_SRC_A;
        state_next    = S_RA_W;
      end
      S_RA_W: begin
        if (!status.div_busy) begin
          cmd.wr_dst = WR_A;
          state_next = S_RB;
        end
      end
      S_RB: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = DIV_SRC_B;
        state_next    = S_RB_W;
      end
      S_RB_W: begin
        if (!status.div_busy) begin
          cmd.wr_dst = WR_B;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        priority if (status.act == ACT_MULTIPLY) begin
          kind_next  = MUL_AB;
          state_next = S_MUL;
        end else if (status.act == ACT_DIVIDE) begin
          cmd.pw_init = PW_DIV;
          state_next  = S_PCHK;
        end else if (status.act == ACT_POWER) begin
          cmd.pw_init = PW_POW;
          state_next  = S_PCHK;
        end else begin
          cmd.res_op = RES_SIMPLE;
          state_next = S_OUT;
        end
      end
      S_MUL: begin
        cmd.mul_start = 1'b1;
        state_next    = S_MDIV;
      end
      S_MDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = DIV_SRC_PROD;
        state_next    = S_MWAIT;
      end
      S_MWAIT: begin
        if (!status.div_busy) begin
          unique case (kind)
            MUL_ACC_BASE: begin
              cmd.wr_dst = WR_ACC;
              kind_next  = MUL_SQUARE;
              state_next = S_MUL;
            end
            MUL_SQUARE: begin
              cmd.wr_dst  = WR_BASE;
              cmd.e_shift = 1'b1;
              state_next  = S_PCHK;
            end
            default: begin
              cmd.wr_dst = WR_RES;
              state_next = S_OUT;
            end
          endcase
        end
      end
      S_PCHK: begin
        if (status.e_zero) begin
          if (status.act == ACT_DIVIDE) begin
            kind_next  = MUL_FINAL;
            state_next = S_MUL;
          end else begin
            cmd.res_op = RES_ACC;
            state_next = S_OUT;
          end
        end else begin
          kind_next  = status.e_lsb ? MUL_ACC_BASE : MUL_SQUARE;
          state_next = S_MUL;
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      kind      <= MUL_AB;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      kind  <= kind_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/modular_arithmetic_unit.sv]
// Each modular reduction runs the bit-serial remainder unit for 64 restoring steps. Every
// action first reduces both operands; multiply adds one product reduction, power one squaring
// per exponent bit plus one multiply per set bit, divide the same for modulus-2 plus a final
// multiply. With a modulus below two the result is zero and no reduction runs.
// One transaction at a time; in_ready rises as the result enters the output register, which
// may still wait. Reset (rst, synchronous): idle, modulus 1000000007.
module modular_arithmetic_unit import mau_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  // input transaction
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [ACT_W-1:0]        action,
  input  logic signed [OPA_W-1:0] operand_a,
  input  logic [OPB_W-1:0]        operand_b,
  input  logic [EXP_W-1:0]        exponent,
  // result transaction
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [MOD_W-1:0]        result,
  // APB-style configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_AW-1:0]       paddr,
  input  logic [APB_DW-1:0]       pwdata,
  output logic [APB_DW-1:0]       prdata,
  output logic                    pready
);

  mau_cmd_t         cmd;
  mau_status_t      status;
  logic [MOD_W-1:0] modulus_r;
  logic             reg_hit;

  // Configuration register file: a single word, the field modulus.
  // Writes land on the access phase; low address bits select bytes and are ignored.
  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_AW-1] == REG_MODULUS);
  assign prdata  = reg_hit ? APB_DW'(modulus_r) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus_r <= RESET_MODULUS;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      modulus_r <= pwdata[MOD_W-1:0];
    end
  end

  // Controller: walks each transaction through operand reduction (skipped when
  // the modulus is below two), then either a combinational reduce/add/subtract/negate
  // result, a single modular multiply, or the square-and-multiply loop (divide runs it
  // with exponent modulus-2, then one more multiply by the reduced left operand).
  mau_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: 31x31 multiplier registered into a product register, and a
  // restoring remainder unit shared by all reductions (signed operand, right
  // operand and every product).
  mau_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .action    (action),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .exponent  (exponent),
    .modulus   (modulus_r),
    .status    (status),
    .result    (result)
  );

endmodule
